### hdl/mesf_pkg.sv
package mesf_pkg;

  // field and state widths
  localparam int COORD_BITS = 16;
  localparam int OUT_BITS   = COORD_BITS + 1;
  localparam int RAD_BITS   = 10;
  localparam int RADIUS_MAX = 1023;
  localparam int STEP_BITS  = 12;
  localparam int SQ_BITS    = 2 * RAD_BITS;
  localparam int SLOPE_BITS = 33;
  localparam int DEC_BITS   = 48;
  localparam int MUL_BITS   = 2 * STEP_BITS;
  localparam int PROD_BITS  = 2 * MUL_BITS;

  // request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // multiplier operand selects
  localparam logic [2:0] MUL_RX_RX     = 3'd0;
  localparam logic [2:0] MUL_RY_RY     = 3'd1;
  localparam logic [2:0] MUL_RXSQ_RY   = 3'd2;
  localparam logic [2:0] MUL_TX_TX     = 3'd3;
  localparam logic [2:0] MUL_TY_TY     = 3'd4;
  localparam logic [2:0] MUL_RYSQ_A    = 3'd5;
  localparam logic [2:0] MUL_RXSQ_B    = 3'd6;
  localparam logic [2:0] MUL_RXSQ_RYSQ = 3'd7;

  // product write-back selects
  localparam logic [3:0] WR_NONE    = 4'd0;
  localparam logic [3:0] WR_RXSQ    = 4'd1;
  localparam logic [3:0] WR_RYSQ    = 4'd2;
  localparam logic [3:0] WR_P1      = 4'd3;
  localparam logic [3:0] WR_A       = 4'd4;
  localparam logic [3:0] WR_B       = 4'd5;
  localparam logic [3:0] WR_ACC     = 4'd6;
  localparam logic [3:0] WR_ACC_ADD = 4'd7;
  localparam logic [3:0] WR_P2      = 4'd8;

  typedef struct packed {
    logic       load;
    logic [2:0] mul_sel;
    logic [3:0] wr_sel;
    logic       step1;
    logic       step2;
  } mesf_cmd_t;

  typedef struct packed {
    logic sw_due;
    logic y_end;
    logic out_busy;
  } mesf_sts_t;

  // quarter units to whole units, truncating toward zero
  function automatic logic signed [DEC_BITS-1:0] trunc_quarter(
    input logic signed [DEC_BITS-1:0] q
  );
    logic signed [DEC_BITS-1:0] bias;
    bias = q[DEC_BITS-1] ? DEC_BITS'(3) : '0;
    return (q + bias) >>> 2;
  endfunction

endpackage

### hdl/mesf_if.sv
interface mesf_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     req_type;
  logic signed [mesf_pkg::COORD_BITS-1:0]   ctr_x;
  logic signed [mesf_pkg::COORD_BITS-1:0]   ctr_y;
  logic        [mesf_pkg::RAD_BITS-1:0]     rad_x;
  logic        [mesf_pkg::RAD_BITS-1:0]     rad_y;

  modport source (output valid, req_type, ctr_x, ctr_y, rad_x, rad_y,
                  input ready);
  modport sink   (input valid, req_type, ctr_x, ctr_y, rad_x, rad_y,
                  output ready);
endinterface

interface mesf_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mesf_pkg::OUT_BITS-1:0]   span_left;
  logic signed [mesf_pkg::OUT_BITS-1:0]   span_right;
  logic signed [mesf_pkg::OUT_BITS-1:0]   row_below;
  logic signed [mesf_pkg::OUT_BITS-1:0]   row_above;
  logic                                   last_span;

  modport source (output valid, span_left, span_right, row_below, row_above, last_span,
                  input ready);
  modport sink   (input valid, span_left, span_right, row_below, row_above, last_span,
                  output ready);
endinterface

### hdl/mesf_dp.sv
module mesf_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mesf_pkg::mesf_cmd_t                    cmd,
  output mesf_pkg::mesf_sts_t                    sts,
  input  logic signed [mesf_pkg::COORD_BITS-1:0] ctr_x,
  input  logic signed [mesf_pkg::COORD_BITS-1:0] ctr_y,
  input  logic        [mesf_pkg::RAD_BITS-1:0]   rad_x,
  input  logic        [mesf_pkg::RAD_BITS-1:0]   rad_y,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic signed [mesf_pkg::OUT_BITS-1:0]   span_left,
  output logic signed [mesf_pkg::OUT_BITS-1:0]   span_right,
  output logic signed [mesf_pkg::OUT_BITS-1:0]   row_below,
  output logic signed [mesf_pkg::OUT_BITS-1:0]   row_above,
  output logic                                   last_span
);

  logic signed [mesf_pkg::COORD_BITS-1:0] origin_x_r, origin_y_r;
  logic        [mesf_pkg::RAD_BITS-1:0]   rx_r, ry_r;
  logic        [mesf_pkg::RAD_BITS-1:0]   rx_clamp, ry_clamp;
  logic signed [mesf_pkg::STEP_BITS-1:0]  step_x_r, step_y_r;
  logic        [mesf_pkg::SQ_BITS-1:0]    rx_sq_r, ry_sq_r;
  logic signed [mesf_pkg::SLOPE_BITS-1:0] slope_px_r, slope_py_r;
  logic signed [mesf_pkg::DEC_BITS-1:0]   decision_r, acc_r;
  logic        [mesf_pkg::MUL_BITS-1:0]   tmp_a_r, tmp_b_r;
  logic        [mesf_pkg::PROD_BITS-1:0]  prod_r;
  logic        [mesf_pkg::MUL_BITS-1:0]   mul_a, mul_b;
  logic        [mesf_pkg::PROD_BITS-1:0]  mul_p;
  logic        [mesf_pkg::STEP_BITS-1:0]  tx, ty_abs;
  logic signed [mesf_pkg::STEP_BITS-1:0]  ty;
  logic signed [mesf_pkg::SLOPE_BITS-1:0] two_rx_sq, two_ry_sq, spx_inc, spy_dec;
  logic signed [mesf_pkg::DEC_BITS-1:0]   prod_s, prod_x4, rx_sq_s, ry_sq_s;
  logic signed [mesf_pkg::DEC_BITS-1:0]   spx_inc_s, spy_dec_s, q1, q2;
  logic signed [mesf_pkg::DEC_BITS-1:0]   d_r1_neg, d_r1_pos, d_r2_pos, d_r2_neg;
  logic                                   dec_pos;
  logic                                   out_valid_r, last_span_r;
  logic signed [mesf_pkg::OUT_BITS-1:0]   span_left_r, span_right_r;
  logic signed [mesf_pkg::OUT_BITS-1:0]   row_below_r, row_above_r;
  logic signed [mesf_pkg::OUT_BITS-1:0]   ox_ext, oy_ext, x_ext, y_ext;

  assign rx_clamp = (rad_x > mesf_pkg::RAD_BITS'(mesf_pkg::RADIUS_MAX)) ?
                    mesf_pkg::RAD_BITS'(mesf_pkg::RADIUS_MAX) : rad_x;
  assign ry_clamp = (rad_y > mesf_pkg::RAD_BITS'(mesf_pkg::RADIUS_MAX)) ?
                    mesf_pkg::RAD_BITS'(mesf_pkg::RADIUS_MAX) : rad_y;

  // region-switch operands: 2x+1 and |y-1| (x is never negative)
  assign tx     = {step_x_r[mesf_pkg::STEP_BITS-2:0], 1'b1};
  assign ty     = step_y_r - mesf_pkg::STEP_BITS'(1);
  assign ty_abs = ty[mesf_pkg::STEP_BITS-1] ? (-ty) : ty;

  always_comb begin
    case (cmd.mul_sel)
      mesf_pkg::MUL_RX_RX: begin
        mul_a = mesf_pkg::MUL_BITS'(rx_r);
        mul_b = mesf_pkg::MUL_BITS'(rx_r);
      end
      mesf_pkg::MUL_RY_RY: begin
        mul_a = mesf_pkg::MUL_BITS'(ry_r);
        mul_b = mesf_pkg::MUL_BITS'(ry_r);
      end
      mesf_pkg::MUL_RXSQ_RY: begin
        mul_a = mesf_pkg::MUL_BITS'(rx_sq_r);
        mul_b = mesf_pkg::MUL_BITS'(ry_r);
      end
      mesf_pkg::MUL_TX_TX: begin
        mul_a = mesf_pkg::MUL_BITS'(tx);
        mul_b = mesf_pkg::MUL_BITS'(tx);
      end
      mesf_pkg::MUL_TY_TY: begin
        mul_a = mesf_pkg::MUL_BITS'(ty_abs);
        mul_b = mesf_pkg::MUL_BITS'(ty_abs);
      end
      mesf_pkg::MUL_RYSQ_A: begin
        mul_a = mesf_pkg::MUL_BITS'(ry_sq_r);
        mul_b = tmp_a_r;
      end
      mesf_pkg::MUL_RXSQ_B: begin
        mul_a = mesf_pkg::MUL_BITS'(rx_sq_r);
        mul_b = tmp_b_r;
      end
      mesf_pkg::MUL_RXSQ_RYSQ: begin
        mul_a = mesf_pkg::MUL_BITS'(rx_sq_r);
        mul_b = mesf_pkg::MUL_BITS'(ry_sq_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign prod_s  = $signed(mesf_pkg::DEC_BITS'(prod_r));
  assign prod_x4 = prod_s <<< 2;
  assign rx_sq_s = $signed(mesf_pkg::DEC_BITS'(rx_sq_r));
  assign ry_sq_s = $signed(mesf_pkg::DEC_BITS'(ry_sq_r));

  // 4*p1 = 4*ry^2 - 4*rx^2*ry + rx^2 ; 4*p2 = acc - 4*rx^2*ry^2
  assign q1 = (ry_sq_s <<< 2) - prod_x4 + rx_sq_s;
  assign q2 = acc_r - prod_x4;

  assign two_rx_sq = $signed(mesf_pkg::SLOPE_BITS'({rx_sq_r, 1'b0}));
  assign two_ry_sq = $signed(mesf_pkg::SLOPE_BITS'({ry_sq_r, 1'b0}));
  assign spx_inc   = slope_px_r + two_ry_sq;
  assign spy_dec   = slope_py_r - two_rx_sq;
  assign spx_inc_s = mesf_pkg::DEC_BITS'(spx_inc);
  assign spy_dec_s = mesf_pkg::DEC_BITS'(spy_dec);

  assign d_r1_neg = decision_r + ry_sq_s + spx_inc_s;
  assign d_r1_pos = decision_r + ry_sq_s + spx_inc_s - spy_dec_s;
  assign dec_pos  = !decision_r[mesf_pkg::DEC_BITS-1] && (decision_r != '0);
  assign d_r2_pos = decision_r + rx_sq_s - spy_dec_s;
  assign d_r2_neg = decision_r + rx_sq_s - spy_dec_s + spx_inc_s;

  assign ox_ext = mesf_pkg::OUT_BITS'(origin_x_r);
  assign oy_ext = mesf_pkg::OUT_BITS'(origin_y_r);
  assign x_ext  = mesf_pkg::OUT_BITS'(step_x_r);
  assign y_ext  = mesf_pkg::OUT_BITS'(step_y_r);

  always_ff @(posedge clk) begin
    prod_r <= mul_p;

    if (cmd.load) begin
      origin_x_r <= ctr_x;
      origin_y_r <= ctr_y;
      rx_r       <= rx_clamp;
      ry_r       <= ry_clamp;
      step_x_r   <= '0;
      step_y_r   <= mesf_pkg::STEP_BITS'(ry_clamp);
      slope_px_r <= '0;
    end

    if (cmd.step1 || cmd.step2) begin
      span_left_r  <= ox_ext - x_ext;
      span_right_r <= ox_ext + x_ext;
      row_below_r  <= oy_ext + y_ext;
      row_above_r  <= oy_ext - y_ext;
      last_span_r  <= cmd.step2 && sts.y_end;
    end

    if (cmd.step1) begin
      step_x_r   <= step_x_r + mesf_pkg::STEP_BITS'(1);
      slope_px_r <= spx_inc;
      if (decision_r[mesf_pkg::DEC_BITS-1]) begin
        decision_r <= d_r1_neg;
      end else begin
        step_y_r   <= step_y_r - mesf_pkg::STEP_BITS'(1);
        slope_py_r <= spy_dec;
        decision_r <= d_r1_pos;
      end
    end

    if (cmd.step2) begin
      step_y_r   <= step_y_r - mesf_pkg::STEP_BITS'(1);
      slope_py_r <= spy_dec;
      if (dec_pos) begin
        decision_r <= d_r2_pos;
      end else begin
        step_x_r   <= step_x_r + mesf_pkg::STEP_BITS'(1);
        slope_px_r <= spx_inc;
        decision_r <= d_r2_neg;
      end
    end

    case (cmd.wr_sel)
      mesf_pkg::WR_RXSQ: rx_sq_r <= prod_r[mesf_pkg::SQ_BITS-1:0];
      mesf_pkg::WR_RYSQ: ry_sq_r <= prod_r[mesf_pkg::SQ_BITS-1:0];
      mesf_pkg::WR_P1: begin
        slope_py_r <= $signed({prod_r[mesf_pkg::SLOPE_BITS-2:0], 1'b0});
        decision_r <= mesf_pkg::trunc_quarter(q1);
      end
      mesf_pkg::WR_A:       tmp_a_r <= prod_r[mesf_pkg::MUL_BITS-1:0];
      mesf_pkg::WR_B:       tmp_b_r <= prod_r[mesf_pkg::MUL_BITS-1:0];
      mesf_pkg::WR_ACC:     acc_r   <= prod_s;
      mesf_pkg::WR_ACC_ADD: acc_r   <= acc_r + prod_x4;
      mesf_pkg::WR_P2:      decision_r <= mesf_pkg::trunc_quarter(q2);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step1 || cmd.step2) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.sw_due   = !(slope_px_r < slope_py_r);
  assign sts.y_end    = step_y_r[mesf_pkg::STEP_BITS-1] || (step_y_r == '0);
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign span_left  = span_left_r;
  assign span_right = span_right_r;
  assign row_below  = row_below_r;
  assign row_above  = row_above_r;
  assign last_span  = last_span_r;

endmodule

### hdl/mesf_ctrl.sv
module mesf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                req_type,
  output logic                in_ready,
  output mesf_pkg::mesf_cmd_t cmd,
  input  mesf_pkg::mesf_sts_t sts
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_R1    = 4'd1;
  localparam logic [3:0] ST_R2    = 4'd2;
  localparam logic [3:0] ST_SQX   = 4'd3;
  localparam logic [3:0] ST_SQY   = 4'd4;
  localparam logic [3:0] ST_RXRY  = 4'd5;
  localparam logic [3:0] ST_P1    = 4'd6;
  localparam logic [3:0] ST_SW1   = 4'd7;
  localparam logic [3:0] ST_SW2   = 4'd8;
  localparam logic [3:0] ST_SW3   = 4'd9;
  localparam logic [3:0] ST_SW4   = 4'd10;
  localparam logic [3:0] ST_SW5   = 4'd11;
  localparam logic [3:0] ST_SW6   = 4'd12;
  localparam logic [3:0] ST_EMIT2 = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       waiting, in_fire;

  assign waiting  = (state_r == ST_IDLE) || (state_r == ST_R1) || (state_r == ST_R2);
  assign in_ready = waiting && !sts.out_busy;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = mesf_pkg::MUL_RX_RX;
    cmd.wr_sel  = mesf_pkg::WR_NONE;
    state_nxt   = state_r;
    case (state_r)
      ST_IDLE, ST_R1, ST_R2: begin
        if (in_fire) begin
          if (req_type == mesf_pkg::REQ_START) begin
            cmd.load  = 1'b1;
            state_nxt = ST_SQX;
          end else if (state_r == ST_R1) begin
            if (sts.sw_due) begin
              state_nxt = ST_SW1;
            end else begin
              cmd.step1 = 1'b1;
            end
          end else if (state_r == ST_R2) begin
            cmd.step2 = 1'b1;
            if (sts.y_end) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_SQX: begin
        cmd.mul_sel = mesf_pkg::MUL_RX_RX;
        state_nxt   = ST_SQY;
      end
      ST_SQY: begin
        cmd.mul_sel = mesf_pkg::MUL_RY_RY;
        cmd.wr_sel  = mesf_pkg::WR_RXSQ;
        state_nxt   = ST_RXRY;
      end
      ST_RXRY: begin
        cmd.mul_sel = mesf_pkg::MUL_RXSQ_RY;
        cmd.wr_sel  = mesf_pkg::WR_RYSQ;
        state_nxt   = ST_P1;
      end
      ST_P1: begin
        cmd.wr_sel = mesf_pkg::WR_P1;
        state_nxt  = ST_R1;
      end
      ST_SW1: begin
        cmd.mul_sel = mesf_pkg::MUL_TX_TX;
        state_nxt   = ST_SW2;
      end
      ST_SW2: begin
        cmd.mul_sel = mesf_pkg::MUL_TY_TY;
        cmd.wr_sel  = mesf_pkg::WR_A;
        state_nxt   = ST_SW3;
      end
      ST_SW3: begin
        cmd.mul_sel = mesf_pkg::MUL_RYSQ_A;
        cmd.wr_sel  = mesf_pkg::WR_B;
        state_nxt   = ST_SW4;
      end
      ST_SW4: begin
        cmd.mul_sel = mesf_pkg::MUL_RXSQ_B;
        cmd.wr_sel  = mesf_pkg::WR_ACC;
        state_nxt   = ST_SW5;
      end
      ST_SW5: begin
        cmd.mul_sel = mesf_pkg::MUL_RXSQ_RYSQ;
        cmd.wr_sel  = mesf_pkg::WR_ACC_ADD;
        state_nxt   = ST_SW6;
      end
      ST_SW6: begin
        cmd.wr_sel = mesf_pkg::WR_P2;
        state_nxt  = ST_EMIT2;
      end
      ST_EMIT2: begin
        cmd.step2 = 1'b1;
        state_nxt = sts.y_end ? ST_IDLE : ST_R2;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && req_type == mesf_pkg::REQ_START) |-> ##5 (state_r == ST_R1))
    else $error("start sequence did not reach region one");

  a_switch_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && state_r == ST_R1 && req_type == mesf_pkg::REQ_STEP && sts.sw_due)
    |-> ##7 cmd.step2)
    else $error("region switch did not emit its pair");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step1 || cmd.step2) |-> !sts.out_busy)
    else $error("step issued while output register occupied");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step2 && sts.y_end) |=> (state_r == ST_IDLE))
    else $error("last pair did not return to idle");

endmodule

### hdl/midpoint_ellipse_span_fill.sv
// Filled-ellipse span generator (two-region midpoint). A start request loads
// centre and radii and gives no result; after acceptance it occupies the
// block while the shared 24x24 multiplier forms rx^2, ry^2 and rx^2*ry and
// the region-one decision value is set. Each step request then returns one
// mirrored span pair. An ordinary step is taken in the cycle it is accepted
// and the pair appears in the output register on the next cycle, so steps
// run at one per cycle while the sink keeps ready high. On the single step
// where region one gives way to region two, passes through the multiplier
// and its write-back form the region-two decision value before the pair is
// emitted. A step while idle is accepted and dropped; a start between steps
// restarts the ellipse. The pair that carries last_span puts the block back
// to idle. Requests are not accepted while the multiplier sequence runs or
// while an undelivered pair is held.

module midpoint_ellipse_span_fill (
  input  logic        clk,
  input  logic        rst_n,
  mesf_in_if.sink     in_ch,
  mesf_out_if.source  out_ch
);

  mesf_pkg::mesf_cmd_t cmd;
  mesf_pkg::mesf_sts_t sts;

  // sequencer: owns the request handshake and the multiplier schedule
  mesf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .req_type (in_ch.req_type),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: ellipse state, shared multiplier, incremental update, output reg
  mesf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .ctr_x      (in_ch.ctr_x),
    .ctr_y      (in_ch.ctr_y),
    .rad_x      (in_ch.rad_x),
    .rad_y      (in_ch.rad_y),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .span_left  (out_ch.span_left),
    .span_right (out_ch.span_right),
    .row_below  (out_ch.row_below),
    .row_above  (out_ch.row_above),
    .last_span  (out_ch.last_span)
  );

endmodule
